FILE: hw/rtl/nbmd_pkg.sv
// Shared constants and types for the nine-bit message deframer.
// No dependencies; imported by every module of the block.
package nbmd_pkg;

    localparam int MAX_BYTES  = 18;
    localparam int ADDR_W     = $clog2(MAX_BYTES);
    localparam int POS_W      = $clog2(MAX_BYTES + 1);
    localparam int IDX_W      = 5;
    localparam int NIB_W      = 4;
    localparam int LEN_OFFSET = 3;
    localparam int BYTE_W     = 8;

    // memory access request from the sequencer to the store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } nbmd_mem_req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } nbmd_state_t;

endpackage

FILE: hw/rtl/nbmd_store.sv
// Message store: single-port-write, single-port-read memory, registered read.
// Depends on nbmd_pkg. Per-entry valid flags make unwritten entries read as zero.
module nbmd_store (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  nbmd_pkg::nbmd_mem_req_t req,
    output logic [nbmd_pkg::BYTE_W-1:0] rdata
);
    import nbmd_pkg::*;

    logic [BYTE_W-1:0]    mem [MAX_BYTES];
    logic [MAX_BYTES-1:0] valid_reg;
    logic [BYTE_W-1:0]    rdata_reg;
    logic                 rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (req.we) begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re) begin
                rvalid_reg <= valid_reg[req.raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: hw/rtl/nbmd_ctrl.sv
// Sequencer: write pointer, message state and read-out of stored messages.
// Depends on nbmd_pkg; drives the request port of nbmd_store.
module nbmd_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [nbmd_pkg::BYTE_W-1:0] s_byte,
    input  logic                        s_cmd,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [nbmd_pkg::IDX_W-1:0]  m_index,
    output logic                        m_last,
    output nbmd_pkg::nbmd_mem_req_t     req
);
    import nbmd_pkg::*;

    nbmd_state_t       state_reg, state_next;
    logic [POS_W-1:0]  wp_reg, wp_next;
    logic              started_reg, started_next;
    logic [NIB_W-1:0]  nib_reg, nib_next;
    logic [BYTE_W-1:0] pend_reg, pend_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              slot_free;
    logic              final_rd;
    logic [POS_W-1:0]  raw_len;
    logic [POS_W-1:0]  rd_count;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign raw_len   = POS_W'(nib_reg) + POS_W'(LEN_OFFSET);
    assign rd_count  = POS_W'(rd_ptr_reg) + POS_W'(1);
    assign final_rd  = (rd_count == len_reg);

    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        started_next = started_reg;
        nib_next     = nib_reg;
        pend_next    = pend_reg;
        rd_ptr_next  = rd_ptr_reg;
        len_next     = len_reg;
        m_valid_next = m_valid_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        req          = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd && started_reg) begin
                        // hold the new byte until the old message is out
                        pend_next   = s_byte;
                        rd_ptr_next = '0;
                        len_next    = (raw_len > POS_W'(MAX_BYTES)) ?
                                      POS_W'(MAX_BYTES) : raw_len;
                        state_next  = ST_EMIT;
                    end else if (s_cmd) begin
                        started_next = 1'b1;
                        req.we       = 1'b1;
                        req.waddr    = '0;
                        req.wdata    = s_byte;
                        wp_next      = POS_W'(1);
                    end else if (wp_reg < POS_W'(MAX_BYTES)) begin
                        req.we    = 1'b1;
                        req.waddr = wp_reg[ADDR_W-1:0];
                        req.wdata = s_byte;
                        wp_next   = wp_reg + POS_W'(1);
                        if (wp_reg == POS_W'(1)) begin
                            nib_next = s_byte[NIB_W-1:0];
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    req.re       = 1'b1;
                    req.raddr    = rd_ptr_reg;
                    m_valid_next = 1'b1;
                    idx_next     = IDX_W'(rd_ptr_reg);
                    last_next    = final_rd;
                    rd_ptr_next  = rd_ptr_reg + ADDR_W'(1);
                    if (final_rd) begin
                        // restart the store with the held byte
                        req.we     = 1'b1;
                        req.waddr  = '0;
                        req.wdata  = pend_reg;
                        wp_next    = POS_W'(1);
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            started_reg <= 1'b0;
            nib_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            started_reg <= started_next;
            nib_reg     <= nib_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        rd_ptr_reg <= rd_ptr_next;
        len_reg    <= len_next;
        idx_reg    <= idx_next;
        last_reg   <= last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_index = idx_reg;
    assign m_last  = last_reg;

endmodule

FILE: hw/rtl/ninth_bit_message_deframer_core.sv
// Top level of the nine-bit message deframer.
// Depends on nbmd_pkg, nbmd_store and nbmd_ctrl.
//
// Usage:
//   Slave side: one request per received nine-bit word. s_tdata carries the
//   data byte, s_tuser the ninth (command) bit. A command word starts a new
//   message; other words append to the message store, which holds 18 bytes
//   and drops bytes once full.
//   Master side: on a command word that follows an earlier command word,
//   the stored message is sent out, one byte per request, with m_tlast on
//   the final byte. The run length is the low nibble of stored byte 1 plus 3.
//   Throughput: a plain data word does not stall the slave side. A command
//   word that sends a message holds s_tready low during read-out through
//   the single read port of the message store, which gives one byte per
//   cycle while m_tready allows; the first byte is read in the emit state.
//   Reset (aresetn low, synchronous): store reads as all zero through per-
//   entry valid flags, write position and message state clear; no clearing
//   pass, so the block is ready as soon as reset is released.
//   Stalls: when m_tready is low, the byte in the output register holds and
//   store reads pause. s_tready is low only while a message is read out; a
//   new word is taken while the last byte of a message still waits.
module ninth_bit_message_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command_flag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [12:8] byte_index, [15:13] zero
    output logic        m_tlast    // last_byte
);
    import nbmd_pkg::*;

    nbmd_mem_req_t     mem_req;
    logic [BYTE_W-1:0] rd_byte;
    logic [IDX_W-1:0]  out_idx;

    // sequencer: write pointer, started flag, length shadow, read-out
    nbmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_byte  (s_tdata),
        .s_cmd   (s_tuser),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_index (out_idx),
        .m_last  (m_tlast),
        .req     (mem_req)
    );

    // message store; its registered read data is the output byte register
    nbmd_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rdata   (rd_byte)
    );

    assign m_tdata = {3'b000, out_idx, rd_byte};

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for ninth_bit_message_deframer_core.
// Depends on nbmd_pkg and the deframer RTL; predicts emitted messages and
// checks every master-side request against the prediction.
`timescale 1ns / 100ps

module tb;
    import nbmd_pkg::MAX_BYTES;
    import nbmd_pkg::IDX_W;
    import nbmd_pkg::BYTE_W;
    import nbmd_pkg::NIB_W;
    import nbmd_pkg::LEN_OFFSET;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_GUARD    = 20000;
    localparam int TAIL_CYCLES    = 25;
    localparam int MAX_PRINTED    = 40;

    // one received nine-bit word waiting to be offered
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              cmd;
        bit                drain_first;  // hold back until all output has arrived
    } rx_word_t;

    // one byte of an emitted message as it should appear on the master side
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } msg_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] data_byte
    logic        s_tuser = 1'b0; // [0] command_flag
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [7:0] out_byte, [12:8] byte_index, [15:13] zero
    logic        m_tlast;        // last_byte

    rx_word_t  pending_words[$];
    msg_byte_t expected_bytes[$];

    // predictor state
    logic [BYTE_W-1:0] msg_store [MAX_BYTES];
    int                wr_pos = 0;
    bit                msg_open = 1'b0;

    int  err_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  rx_hold_left = 0;
    logic hold_kick = 1'b0;

    ninth_bit_message_deframer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    // Apply one accepted word to the predicted store; a command word that
    // follows an earlier one queues the stored message up to its run length.
    task automatic deframe_word(input logic [BYTE_W-1:0] data, input logic cmd);
        int        run_len;
        msg_byte_t mb;
        if (cmd) begin
            if (msg_open) begin
                run_len = int'(msg_store[1][NIB_W-1:0]) + LEN_OFFSET;
                if (run_len > MAX_BYTES) begin
                    run_len = MAX_BYTES;
                end
                for (int i = 0; i < run_len; i++) begin
                    mb.data = msg_store[i];
                    mb.idx  = IDX_W'(i);
                    mb.last = (i == run_len - 1);
                    expected_bytes.push_back(mb);
                end
            end
            msg_open = 1'b1;
            wr_pos   = 0;
        end
        // store full: byte dropped, position stays put
        if (wr_pos < MAX_BYTES) begin
            msg_store[wr_pos] = data;
            wr_pos++;
        end
    endtask

    task automatic queue_word(input logic [BYTE_W-1:0] data, input logic cmd, input bit drain);
        rx_word_t w;
        w.data        = data;
        w.cmd         = cmd;
        w.drain_first = drain;
        pending_words.push_back(w);
    endtask

    // Mostly well-formed messages (command word then a body), some loose noise.
    task automatic queue_random(input int n_items);
        int count;
        int body;
        count = 0;
        while (count < n_items) begin
            if ($urandom_range(9) == 0) begin
                queue_word(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
                count++;
            end else begin
                body = ($urandom_range(3) == 0) ? $urandom_range(17, 21) : $urandom_range(1, 6);
                queue_word(BYTE_W'($urandom_range(255)), 1'b1, $urandom_range(19) == 0);
                repeat (body) queue_word(BYTE_W'($urandom_range(255)), 1'b0, 1'b0);
                count += 1 + body;
            end
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((pending_words.size() != 0 || s_tvalid || expected_bytes.size() != 0)
               && guard < DRAIN_GUARD) begin
            @(negedge aclk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    // Driver: predicts on each accepted request, then offers the next word.
    // A word on offer stays put until accepted.
    always @(posedge aclk) begin : drive
        rx_word_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_word(s_tdata, s_tuser);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(pending_words[0].drain_first && expected_bytes.size() != 0)) begin
                    nxt = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold_left <= 0;
        end else if (hold_kick) begin
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // Monitor: compares each accepted output request with the oldest prediction.
    always @(posedge aclk) begin : watch
        msg_byte_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected byte", int'(m_tdata[BYTE_W-1:0]), -1);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata[BYTE_W-1:0] !== want.data)
                        report_mismatch("out_byte", int'(m_tdata[BYTE_W-1:0]), int'(want.data));
                    if (m_tdata[BYTE_W +: IDX_W] !== want.idx)
                        report_mismatch("byte_index", int'(m_tdata[BYTE_W +: IDX_W]),
                                        int'(want.idx));
                    if (m_tlast !== want.last)
                        report_mismatch("last_byte", int'(m_tlast), int'(want.last));
                end
            end
            m_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int snd_pct [4] = '{0, 52, 0, 6};
        int rcv_pct [4] = '{0, 0, 52, 6};
        for (int i = 0; i < MAX_BYTES; i++) msg_store[i] = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // data ahead of any command: stored, later discarded unsent
        queue_word(8'h00, 1'b0, 1'b0);
        // first command word: nothing sent
        queue_word(8'h5A, 1'b1, 1'b0);
        // nibble zero gives the shortest run; position 2 never written
        queue_word(8'h00, 1'b0, 1'b0);
        queue_word(8'hFF, 1'b1, 1'b0);
        // short message: nibble 14 asks for 17 bytes, only 2 received
        queue_word(8'hFE, 1'b0, 1'b0);
        queue_word(8'h80, 1'b1, 1'b0);
        // nibble 15 asks for exactly the store size; overflow byte dropped
        queue_word(8'h1F, 1'b0, 1'b0);
        for (int i = 0; i < MAX_BYTES - 2; i++) queue_word(8'(8'hE0 + i), 1'b0, 1'b0);
        queue_word(8'hC3, 1'b0, 1'b0);
        queue_word(8'h01, 1'b1, 1'b0);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = snd_pct[p];
            recv_stall_pct = rcv_pct[p];
            queue_random(14);
            wait_drained();
        end

        // receiver holds off while the sender keeps offering, then one word
        // waits until every byte has come out
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_kick <= 1'b1;
        @(posedge aclk);
        hold_kick <= 1'b0;
        queue_random(14);
        queue_word(BYTE_W'($urandom_range(255)), 1'b1, 1'b1);
        queue_random(6);
        queue_word(BYTE_W'($urandom_range(255)), 1'b1, 1'b0);
        wait_drained();

        if (expected_bytes.size() != 0) begin
            report_mismatch("bytes never sent", 0, expected_bytes.size());
        end
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/nbmd_pkg.sv
hw/rtl/nbmd_store.sv
hw/rtl/nbmd_ctrl.sv
hw/rtl/ninth_bit_message_deframer_core.sv
tb/sv/tb.sv
